// ----- rtl/base64url_stream_codec_macros.svh -----
// Assertion helpers for the checker file b64u_checker.sv.
`ifndef BASE64URL_STREAM_CODEC_MACROS_SVH
`define BASE64URL_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define B64U_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define B64U_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/b64u_pkg.sv -----
`timescale 1ns / 1ps
package b64u_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] DASH_CHAR  = 8'h2D;
	localparam logic [7:0] ULINE_CHAR = 8'h5F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       error;
	} out_word_t;

	// One group handed from the front end to the back end.
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  cnt_m1;    // results in this group, minus one
		logic [1:0]  chars_m1;  // encode: real characters minus one, rest are '='
		logic        dec;
		logic        err;
		logic        last;
	} job_t;

	function automatic logic [7:0] sym_of(input logic [5:0] s);
		logic [7:0] w;
		begin
			w = {2'b00, s};
			if (s < 6'd26)
				sym_of = w + 8'h41;
			else if (s < 6'd52)
				sym_of = w + 8'd71;
			else if (s < 6'd62)
				sym_of = w - 8'd4;
			else if (s == 6'd62)
				sym_of = DASH_CHAR;
			else
				sym_of = ULINE_CHAR;
		end
	endfunction

	// Returns {bad, sextet}; bad is set for anything outside the alphabet and not '='.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			sextet_of = 7'b1_000000;
			if (c >= 8'h41 && c <= 8'h5A) begin
				d = c - 8'h41;
				sextet_of = {1'b0, d[5:0]};
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				d = c - 8'd71;
				sextet_of = {1'b0, d[5:0]};
			end else if (c >= 8'h30 && c <= 8'h39) begin
				d = c + 8'd4;
				sextet_of = {1'b0, d[5:0]};
			end else if (c == DASH_CHAR) begin
				sextet_of = 7'd62;
			end else if (c == ULINE_CHAR) begin
				sextet_of = 7'd63;
			end else if (c == PAD_CHAR) begin
				sextet_of = 7'd0;
			end
		end
	endfunction

endpackage

// ----- rtl/b64u_front.sv -----
`timescale 1ns / 1ps
module b64u_front import b64u_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     dir,
	input  logic     clear,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_word,
	input  logic     q_full,
	output logic     push,
	output job_t     push_job
);

	logic [23:0] group_bits_q;
	logic [1:0]  group_count_q;
	logic        third_pad_q;
	logic        bad_q;

	logic        take;
	logic        emit;
	logic [1:0]  held;
	logic [23:0] merged;
	logic [6:0]  dec_s;
	logic        is_pad;
	logic [1:0]  drop;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign held     = group_count_q + 2'd1;
	assign dec_s    = sextet_of(in_word.in_byte);
	assign is_pad   = (in_word.in_byte == PAD_CHAR);
	assign drop     = {1'b0, in_word.in_last && is_pad} + {1'b0, in_word.in_last && third_pad_q};

	always_comb begin
		merged   = group_bits_q;
		emit     = 1'b0;
		push_job = '0;
		if (!dir) begin
			case (group_count_q)
				2'd0:    merged[23:16] = in_word.in_byte;
				2'd1:    merged[15:8]  = in_word.in_byte;
				default: merged[7:0]   = in_word.in_byte;
			endcase
			emit              = (held == 2'd3) || in_word.in_last;
			push_job.bits     = merged;
			push_job.cnt_m1   = 2'd3;
			push_job.chars_m1 = held;
			push_job.last     = in_word.in_last;
		end else begin
			case (group_count_q)
				2'd0:    merged[23:18] = dec_s[5:0];
				2'd1:    merged[17:12] = dec_s[5:0];
				2'd2:    merged[11:6]  = dec_s[5:0];
				default: merged[5:0]   = dec_s[5:0];
			endcase
			emit         = (group_count_q == 2'd3) || in_word.in_last;
			push_job.dec = 1'b1;
			if (group_count_q == 2'd3) begin
				push_job.bits   = merged;
				push_job.cnt_m1 = 2'd2 - drop;
				push_job.err    = bad_q || dec_s[6];
				push_job.last   = in_word.in_last;
			end else begin
				// short final group: a single zero word flagged as error
				push_job.err  = 1'b1;
				push_job.last = 1'b1;
			end
		end
	end

	assign push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_bits_q  <= '0;
			group_count_q <= '0;
			third_pad_q   <= 1'b0;
			bad_q         <= 1'b0;
		end else if (clear || push) begin
			group_bits_q  <= '0;
			group_count_q <= '0;
			third_pad_q   <= 1'b0;
			bad_q         <= 1'b0;
		end else if (take) begin
			group_bits_q  <= merged;
			group_count_q <= held;
			if (dir) begin
				if (dec_s[6])
					bad_q <= 1'b1;
				if (group_count_q == 2'd2 && is_pad)
					third_pad_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/b64u_fifo.sv -----
`timescale 1ns / 1ps
module b64u_fifo import b64u_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = mem[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/b64u_back.sv -----
`timescale 1ns / 1ps
module b64u_back import b64u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      q_job,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	job_t       cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_word_q;

	logic       adv;
	logic       at_end;
	logic [5:0] sext;
	logic [7:0] dbyte;
	out_word_t  res;

	assign adv    = !out_valid_q || !out_stall;
	assign at_end = (idx_q == cur_q.cnt_m1);
	assign pop    = q_valid && (!busy_q || (adv && at_end));

	always_comb begin
		case (idx_q)
			2'd0:    sext = cur_q.bits[23:18];
			2'd1:    sext = cur_q.bits[17:12];
			2'd2:    sext = cur_q.bits[11:6];
			default: sext = cur_q.bits[5:0];
		endcase
		case (idx_q)
			2'd0:    dbyte = cur_q.bits[23:16];
			2'd1:    dbyte = cur_q.bits[15:8];
			default: dbyte = cur_q.bits[7:0];
		endcase
		res.out_last = cur_q.last && at_end;
		res.error    = cur_q.dec && cur_q.err;
		if (cur_q.dec)
			res.out_byte = dbyte;
		else if (idx_q <= cur_q.chars_m1)
			res.out_byte = sym_of(sext);
		else
			res.out_byte = PAD_CHAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= busy_q;
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv && busy_q) begin
				if (at_end)
					busy_q <= 1'b0;
				else
					idx_q <= idx_q + 2'd1;
			end
		end
	end

	// hold the word while stalled
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_job;
		if (adv && busy_q)
			out_word_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ----- rtl/base64url_stream_codec.sv -----
`timescale 1ns / 1ps
// Streaming base64url codec ('-' and '_' alphabet, '=' padding). cfg_wdata written with
// cfg_we selects encode (0) or decode (1) and clears any partly gathered group; write it
// only while the block is idle. The front end takes one input word per cycle while the
// group queue (QUEUE_DEPTH entries) has room and hands each finished group to the back
// end, which emits one output word per cycle from its output register while out_stall
// is low. Encoding gives four characters per three bytes, so the single output word per
// cycle sets the encode rate; decoding takes one character per cycle when not stalled.
// A result passes through the group queue and the back end's group and output registers.
module base64url_stream_codec import b64u_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic dir_q;
	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic q_valid;
	job_t q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dir_q <= 1'b0;
		else if (cfg_we)
			dir_q <= cfg_wdata;
	end

	b64u_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dir      (dir_q),
		.clear    (cfg_we),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	b64u_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	b64u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ----- rtl/b64u_checker.sv -----
`timescale 1ns / 1ps
`include "base64url_stream_codec_macros.svh"
module b64u_checker import b64u_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_we,
	input logic      cfg_wdata,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	logic dir_q;
	logic [7:0] b;
	logic stalled;
	logic enc_active;
	logic sym_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dir_q <= 1'b0;
		else if (cfg_we)
			dir_q <= cfg_wdata;
	end

	assign b          = out_word.out_byte;
	assign stalled    = out_valid && out_stall;
	assign enc_active = out_valid && !dir_q;
	assign sym_ok     = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
	                    (b >= 8'h30 && b <= 8'h39) || b == DASH_CHAR || b == ULINE_CHAR ||
	                    b == PAD_CHAR;

	`B64U_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_word), "word changed while stalled")
	`B64U_ASSERT_NOW(a_enc_no_err, enc_active, !out_word.error, "error flag raised while encoding")
	`B64U_ASSERT_NOW(a_enc_alpha, enc_active, sym_ok, "encoded character outside alphabet")

endmodule

bind base64url_stream_codec b64u_checker u_b64u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
